// ===== rtl/sia_pkg.sv =====
`timescale 1ns / 1ps
package sia_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int SLOT_W        = 8;
    localparam int GRANT_W       = 8;
    localparam int HW_W          = 9;
    localparam int LIMIT_W       = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic {
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_NOT_IN_USE
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
    } t_req;

    // head of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_req req;
    } t_qhead;

    typedef struct packed {
        logic [GRANT_W-1:0] granted;
        t_status            status;
        logic [HW_W-1:0]    high_water;
    } t_result;

endpackage

// ===== rtl/sia_front.sv =====
`timescale 1ns / 1ps
module sia_front import sia_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [0:0]        i_s_tuser,   // [0] mode
    input  logic [SLOT_W-1:0] i_s_tdata,   // [7:0] slot
    output t_qhead            o_q,
    input  logic              i_pop
);

    localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0]   LAST_PTR = QAW'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_req             r_q [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    t_req             req_in;

    assign o_s_tready = i_en && (r_cnt != FULL_CNT);
    assign push       = i_s_tvalid && o_s_tready;

    // classify the request kind
    always_comb begin
        req_in.op   = i_s_tuser[0] ? OP_FREE : OP_ALLOC;
        req_in.slot = i_s_tdata;
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : QAW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : QAW'(r_rp + 1'b1);
            end
            r_cnt <= CNT_W'(r_cnt + CNT_W'(push) - CNT_W'(i_pop));
        end
    end

endmodule

// ===== rtl/sia_back.sv =====
`timescale 1ns / 1ps
module sia_back import sia_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LIMIT_W-1:0] i_limit,
    input  t_qhead             i_q,
    output logic               o_pop,
    output logic               o_clearing,
    output t_result            o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PTR_W = $clog2(NUM_SLOTS + 1);
    localparam int CW    = (PTR_W > LIMIT_W) ? PTR_W : LIMIT_W;
    localparam logic [PTR_W-1:0] NIL   = PTR_W'(NUM_SLOTS);
    localparam logic [CW-1:0]    NIL_C = CW'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_FCHK,
        ST_WRD,
        ST_WACT
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_mark, n_mark;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              m_used [NUM_SLOTS];
    logic [PTR_W-1:0]  m_nxt  [NUM_SLOTS];
    logic [PTR_W-1:0]  m_prv  [NUM_SLOTS];
    logic              r_used_q;
    logic [PTR_W-1:0]  r_nxt_q, r_prv_q;

    logic              used_we, used_wd, nxt_we, prv_we;
    logic [IDX_W-1:0]  used_wa, nxt_wa, prv_wa;
    logic [IDX_W-1:0]  used_ra, nxt_ra, prv_ra;
    logic [PTR_W-1:0]  nxt_wd, prv_wd;

    logic              out_free, out_load;
    logic [PTR_W-1:0]  mark_dec, pv, nx;
    logic [CW-1:0]     mark_c, lim_c, qslot_c, rslot_c;
    logic [IDX_W-1:0]  rslot_idx;

    function automatic logic [GRANT_W-1:0] grant_of(input logic [PTR_W-1:0] v);
        logic [CW-1:0] w;
        begin
            w = CW'(v);
            return w[GRANT_W-1:0];
        end
    endfunction

    function automatic logic [HW_W-1:0] hw_of(input logic [PTR_W-1:0] v);
        logic [CW-1:0] w;
        begin
            w = CW'(v);
            return w[HW_W-1:0];
        end
    endfunction

    assign out_free  = !r_out_valid || i_res_ready;
    assign mark_dec  = PTR_W'(r_mark - 1'b1);
    assign mark_c    = CW'(r_mark);
    assign lim_c     = (CW'(i_limit) < NIL_C) ? CW'(i_limit) : NIL_C;
    assign qslot_c   = CW'(i_q.req.slot);
    assign rslot_c   = CW'(r_slot);
    assign rslot_idx = rslot_c[IDX_W-1:0];
    assign nx        = r_nxt_q;
    // the head entry has no predecessor; its stored back link is stale
    assign pv        = (PTR_W'(r_idx) == r_head) ? NIL : r_prv_q;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_mark   = r_mark;
        n_clr    = r_clr;
        n_idx    = r_idx;
        n_slot   = r_slot;
        n_out    = r_out;
        out_load = 1'b0;
        o_pop    = 1'b0;
        used_we  = 1'b0;
        used_wa  = '0;
        used_wd  = 1'b0;
        nxt_we   = 1'b0;
        nxt_wa   = '0;
        nxt_wd   = '0;
        prv_we   = 1'b0;
        prv_wa   = '0;
        prv_wd   = '0;
        used_ra  = mark_dec[IDX_W-1:0];
        nxt_ra   = mark_dec[IDX_W-1:0];
        prv_ra   = mark_dec[IDX_W-1:0];
        case (r_state)
            ST_CLEAR: begin
                used_we = 1'b1;
                used_wa = r_clr;
                n_clr   = IDX_W'(r_clr + 1'b1);
                if (r_clr == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q.valid && out_free) begin
                    o_pop  = 1'b1;
                    n_slot = i_q.req.slot;
                    if (i_q.req.op == OP_ALLOC) begin
                        if (r_head != NIL) begin
                            n_idx   = r_head[IDX_W-1:0];
                            nxt_ra  = r_head[IDX_W-1:0];
                            n_state = ST_POP;
                        end else if (mark_c < lim_c) begin
                            used_we  = 1'b1;
                            used_wa  = r_mark[IDX_W-1:0];
                            used_wd  = 1'b1;
                            n_mark   = PTR_W'(r_mark + 1'b1);
                            out_load = 1'b1;
                            n_out    = '{grant_of(r_mark), STAT_OK,
                                         hw_of(PTR_W'(r_mark + 1'b1))};
                        end else begin
                            out_load = 1'b1;
                            n_out    = '{'0, STAT_FULL, hw_of(r_mark)};
                        end
                    end else begin
                        used_ra = qslot_c[IDX_W-1:0];
                        n_state = ST_FCHK;
                    end
                end
            end
            ST_POP: begin
                n_head   = nx;
                used_we  = 1'b1;
                used_wa  = r_idx;
                used_wd  = 1'b1;
                out_load = 1'b1;
                n_out    = '{grant_of(PTR_W'(r_idx)), STAT_OK, hw_of(r_mark)};
                n_state  = ST_IDLE;
            end
            ST_FCHK: begin
                if (rslot_c >= mark_c || !r_used_q) begin
                    out_load = 1'b1;
                    n_out    = '{r_slot, STAT_NOT_IN_USE, hw_of(r_mark)};
                    n_state  = ST_IDLE;
                end else if ((rslot_c + CW'(1)) == mark_c) begin
                    used_we = 1'b1;
                    used_wa = rslot_idx;
                    n_mark  = mark_dec;
                    if (mark_dec == '0) begin
                        out_load = 1'b1;
                        n_out    = '{r_slot, STAT_OK, hw_of(mark_dec)};
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_WRD;
                    end
                end else begin
                    used_we = 1'b1;
                    used_wa = rslot_idx;
                    nxt_we  = 1'b1;
                    nxt_wa  = rslot_idx;
                    nxt_wd  = r_head;
                    if (r_head != NIL) begin
                        prv_we = 1'b1;
                        prv_wa = r_head[IDX_W-1:0];
                        prv_wd = PTR_W'(rslot_idx);
                    end
                    n_head   = PTR_W'(rslot_idx);
                    out_load = 1'b1;
                    n_out    = '{r_slot, STAT_OK, hw_of(r_mark)};
                    n_state  = ST_IDLE;
                end
            end
            ST_WRD: begin
                // probe the entry just below the mark
                n_idx   = mark_dec[IDX_W-1:0];
                n_state = ST_WACT;
            end
            ST_WACT: begin
                if (r_used_q) begin
                    out_load = 1'b1;
                    n_out    = '{r_slot, STAT_OK, hw_of(r_mark)};
                    n_state  = ST_IDLE;
                end else begin
                    if (pv != NIL) begin
                        nxt_we = 1'b1;
                        nxt_wa = pv[IDX_W-1:0];
                        nxt_wd = nx;
                        if (nx != NIL) begin
                            prv_we = 1'b1;
                            prv_wa = nx[IDX_W-1:0];
                            prv_wd = pv;
                        end
                    end else begin
                        n_head = nx;
                    end
                    n_mark = mark_dec;
                    if (mark_dec == '0) begin
                        out_load = 1'b1;
                        n_out    = '{r_slot, STAT_OK, hw_of(mark_dec)};
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_WRD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_head      <= NIL;
            r_mark      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_mark  <= n_mark;
            r_clr   <= n_clr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_idx  <= n_idx;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            m_used[used_wa] <= used_wd;
        end
        r_used_q <= m_used[used_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            m_nxt[nxt_wa] <= nxt_wd;
        end
        r_nxt_q <= m_nxt[nxt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prv_we) begin
            m_prv[prv_wa] <= prv_wd;
        end
        r_prv_q <= m_prv[prv_ra];
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten before transfer");

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("request taken during clearing pass");

    a_walk_lowers_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WACT && !r_used_q) |=> (r_mark == PTR_W'($past(r_mark) - 1'b1)))
        else $error("shrink step did not lower the mark");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mark <= NIL) && (r_head <= NIL))
        else $error("mark or list head out of range");

endmodule

// ===== rtl/slab_index_allocator_top.sv =====
`timescale 1ns / 1ps
// Slab index allocator. Each request on the slave stream allocates an index
// (tuser mode 0) or frees the index in tdata (mode 1); each gives exactly one
// result on the master stream with the granted or echoed index, a status
// (ok, full, not in use) and the new high-water mark. Freed indices are reused
// last-in-first-out; freeing the topmost index lowers the mark past every
// free index below it. Requests wait in a two-entry queue while the back-end
// sequencer works, and a result register holds each result until its transfer;
// the back end takes the next request only when that register is empty or is
// being read in the same cycle. In the back end a fresh allocate or a full
// report is answered from the idle state, an allocate from the free list goes
// through a pop state, a free through a check state, and a free of the topmost
// index then walks the entries below the mark, with a read state (link and flag
// memories) and an update state for each probed entry. After reset a clearing
// pass writes every in-use flag to zero, one entry a cycle; no request is
// taken during it, while slot_limit writes are accepted at any time.
module slab_index_allocator_top import sia_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,  // slot_limit
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [0:0]         i_s_tuser,    // [0] mode
    input  logic [7:0]         i_s_tdata,    // [7:0] slot
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [1:0]         o_m_tuser,    // [1:0] status
    output logic [23:0]        o_m_tdata     // [7:0] granted, [16:8] high_water
);

    logic [LIMIT_W-1:0] r_limit;
    t_qhead             q_head;
    logic               pop;
    logic               clearing;
    t_result            res;

    // slot_limit register: written whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_wen) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // front end: accept and classify requests into the queue
    sia_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (!clearing),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_q        (q_head),
        .i_pop      (pop)
    );

    // back end: free list, in-use flags and high-water mark
    sia_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_q         (q_head),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_res       (res),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready)
    );

    // pack the result; pad tdata to whole bytes
    assign o_m_tuser = res.status;
    assign o_m_tdata = {7'd0, res.high_water, res.granted};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import sia_pkg::*;

    localparam int SLOT_COUNT = NUM_SLOTS_DEF;
    localparam logic [HW_W-1:0] LIST_END = 9'(SLOT_COUNT);
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED = 40;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [LIMIT_W-1:0] limit;
        bit                 typed;
        t_result            want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wen;
    logic [LIMIT_W-1:0] i_cfg_wdata;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [0:0]         i_s_tuser;
    logic [7:0]         i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [1:0]         o_m_tuser;
    logic [23:0]        o_m_tdata;

    slab_index_allocator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata)
    );

    // allocator state as the testbench sees it
    bit                 slot_busy [SLOT_COUNT];
    logic [HW_W-1:0]    free_next [SLOT_COUNT];
    logic [HW_W-1:0]    free_prev [SLOT_COUNT];
    logic [HW_W-1:0]    free_head;
    logic [HW_W-1:0]    hw_mark;
    logic [LIMIT_W-1:0] limit_q;

    t_result  grant_expect_q [$];
    t_dir_row directed_rows [$];

    int  mismatches;
    int  results_seen;
    int  requests_sent;
    int  directed_sent;
    int  full_seen;
    int  not_in_use_seen;
    int  top_mark;
    int  idle_cycles;
    int  hold_req_cnt;
    int  hold_ack_cnt;
    int  stall_left;
    bit  send_gaps;
    bit  recv_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void free_list_unlink(input logic [HW_W-1:0] idx);
        logic [HW_W-1:0] nx;
        logic [HW_W-1:0] pv;
        nx = free_next[idx[SLOT_W-1:0]];
        pv = free_prev[idx[SLOT_W-1:0]];
        if (pv < LIST_END) begin
            free_next[pv[SLOT_W-1:0]] = nx;
        end else begin
            free_head = nx;
        end
        if (nx < LIST_END) begin
            free_prev[nx[SLOT_W-1:0]] = pv;
        end
    endfunction

    // Apply one request to the local copy of the allocator, return its result.
    function automatic t_result predict_grant(input t_op op, input logic [SLOT_W-1:0] slot);
        t_result r;
        int      lim;
        r.granted = '0;
        r.status  = STAT_OK;
        if (op == OP_ALLOC) begin
            lim = (int'(limit_q) < SLOT_COUNT) ? int'(limit_q) : SLOT_COUNT;
            if (free_head < LIST_END) begin
                r.granted = free_head[SLOT_W-1:0];
                free_list_unlink(free_head);
                slot_busy[r.granted] = 1'b1;
            end else if (int'(hw_mark) < lim) begin
                r.granted = hw_mark[SLOT_W-1:0];
                slot_busy[hw_mark[SLOT_W-1:0]] = 1'b1;
                hw_mark = hw_mark + 1'b1;
            end else begin
                r.status = STAT_FULL;
            end
        end else begin
            r.granted = slot;
            if (int'(slot) >= int'(hw_mark) || !slot_busy[slot]) begin
                r.status = STAT_NOT_IN_USE;
            end else if (int'(slot) + 1 == int'(hw_mark)) begin
                // shrink the mark past every free index below the top
                slot_busy[slot] = 1'b0;
                hw_mark = hw_mark - 1'b1;
                while (hw_mark > 0 && !slot_busy[hw_mark - 1]) begin
                    free_list_unlink(hw_mark - 1'b1);
                    hw_mark = hw_mark - 1'b1;
                end
            end else begin
                slot_busy[slot] = 1'b0;
                free_next[slot] = free_head;
                free_prev[slot] = LIST_END;
                if (free_head < LIST_END) begin
                    free_prev[free_head[SLOT_W-1:0]] = {1'b0, slot};
                end
                free_head = {1'b0, slot};
            end
        end
        r.high_water = hw_mark;
        return r;
    endfunction

    function automatic t_dir_row req_row(input t_op op, input logic [SLOT_W-1:0] slot);
        t_dir_row row;
        row.kind  = ROW_REQ;
        row.op    = op;
        row.slot  = slot;
        row.limit = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_dir_row chk_row(input t_op op, input logic [SLOT_W-1:0] slot,
                                         input logic [GRANT_W-1:0] g, input t_status st,
                                         input logic [HW_W-1:0] hw);
        t_dir_row row;
        row = req_row(op, slot);
        row.typed           = 1'b1;
        row.want.granted    = g;
        row.want.status     = st;
        row.want.high_water = hw;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [LIMIT_W-1:0] v);
        t_dir_row row;
        row       = req_row(OP_ALLOC, '0);
        row.kind  = ROW_CFG;
        row.limit = v;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        end
    endtask

    // Offer one request, hold it until the transfer, then queue its expected result.
    task automatic send_request(input t_op op, input logic [SLOT_W-1:0] slot,
                                input bit typed, input t_result want);
        t_result predicted;
        while (send_gaps && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= slot;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_grant(op, slot);
        grant_expect_q.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Drain the block, then write slot_limit.
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        i_s_tvalid <= 1'b0;
        while (grant_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        limit_q = v;
    endtask

    // Pick a free target: mostly the top index or another in-use one, else any index.
    function automatic logic [SLOT_W-1:0] pick_free_slot();
        int busy_idx [$];
        int pick;
        pick = $urandom_range(99);
        if (pick < 25 && hw_mark > 0 && slot_busy[hw_mark - 1]) begin
            return SLOT_W'(hw_mark - 1);
        end
        if (pick < 80) begin
            for (int i = 0; i < int'(hw_mark); i++) begin
                if (slot_busy[i]) busy_idx.push_back(i);
            end
            if (busy_idx.size() > 0) begin
                return SLOT_W'(busy_idx[$urandom_range(busy_idx.size() - 1)]);
            end
        end
        return SLOT_W'($urandom_range(255));
    endfunction

    // Result checker and receiver-side flow control.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (grant_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(o_m_tdata), -1);
            end else begin
                want = grant_expect_q.pop_front();
                if (o_m_tdata[7:0] !== want.granted) begin
                    report_mismatch("granted", int'(o_m_tdata[7:0]), int'(want.granted));
                end
                if (o_m_tuser !== want.status) begin
                    report_mismatch("status", int'(o_m_tuser), int'(want.status));
                end
                if (o_m_tdata[16:8] !== want.high_water) begin
                    report_mismatch("high_water", int'(o_m_tdata[16:8]),
                                    int'(want.high_water));
                end
                if (want.status == STAT_FULL) full_seen++;
                if (want.status == STAT_NOT_IN_USE) not_in_use_seen++;
                if (int'(want.high_water) > top_mark) top_mark = int'(want.high_water);
            end
        end
        if (i_rst_n) begin
            if (hold_ack_cnt != hold_req_cnt) begin
                hold_ack_cnt = hold_req_cnt;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= recv_gaps ? ($urandom_range(99) >= 15) : 1'b1;
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wen || (i_s_tvalid && o_s_tready)
            || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, grant_expect_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int               phase_limit [8];
        int               phase_alloc [8];
        int               phase_items [8];
        t_op              op;
        logic [SLOT_W-1:0] slot;

        i_rst_n     <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tuser   <= '0;
        i_s_tdata   <= '0;
        i_m_tready  <= 1'b0;
        mismatches      = 0;
        results_seen    = 0;
        requests_sent   = 0;
        full_seen       = 0;
        not_in_use_seen = 0;
        top_mark        = 0;
        idle_cycles     = 0;
        hold_req_cnt    = 0;
        hold_ack_cnt    = 0;
        stall_left      = 0;
        send_gaps       = 1'b1;
        recv_gaps       = 1'b1;

        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i] = 1'b0;
            free_next[i] = '0;
            free_prev[i] = '0;
        end
        free_head = LIST_END;
        hw_mark   = '0;
        limit_q   = LIMIT_RST;

        // Directed table: after reset, reuse, shrink walk, full, limit extremes.
        directed_rows.push_back(chk_row(OP_FREE,  8'd0,   8'd0,   STAT_NOT_IN_USE, 9'd0));
        directed_rows.push_back(chk_row(OP_FREE,  8'd255, 8'd255, STAT_NOT_IN_USE, 9'd0));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'd255, 8'd0,   STAT_OK,         9'd1));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'hAA,  8'd1,   STAT_OK,         9'd2));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'h55,  8'd2,   STAT_OK,         9'd3));
        directed_rows.push_back(req_row(OP_FREE,  8'd0));
        directed_rows.push_back(chk_row(OP_FREE,  8'd0,   8'd0,   STAT_NOT_IN_USE, 9'd3));
        directed_rows.push_back(req_row(OP_ALLOC, 8'd0));
        directed_rows.push_back(req_row(OP_FREE,  8'd1));
        directed_rows.push_back(req_row(OP_FREE,  8'd2));
        directed_rows.push_back(chk_row(OP_FREE,  8'd5,   8'd5,   STAT_NOT_IN_USE, 9'd1));
        directed_rows.push_back(cfg_row(9'd2));
        directed_rows.push_back(req_row(OP_ALLOC, 8'd0));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'hFF,  8'd0,   STAT_FULL,       9'd2));
        directed_rows.push_back(req_row(OP_FREE,  8'd0));
        directed_rows.push_back(req_row(OP_ALLOC, 8'd0));
        directed_rows.push_back(req_row(OP_FREE,  8'd1));
        directed_rows.push_back(req_row(OP_FREE,  8'd0));
        directed_rows.push_back(cfg_row(9'd0));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'd0,   8'd0,   STAT_FULL,       9'd0));
        directed_rows.push_back(cfg_row(9'd511));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'd0,   8'd0,   STAT_OK,         9'd1));
        directed_rows.push_back(cfg_row(9'd1));
        directed_rows.push_back(chk_row(OP_ALLOC, 8'd0,   8'd0,   STAT_FULL,       9'd1));
        directed_rows.push_back(chk_row(OP_FREE,  8'd0,   8'd0,   STAT_OK,         9'd0));

        // Random phases: limit, percent of allocates, request count.
        phase_limit = '{256, 511, 256,   5,   1, 200, 0, 256};
        phase_alloc = '{ 95,  60,  20,  55,  50,  65, 40,  50};
        phase_items = '{300, 200, 260, 200, 150, 220, 100, 100};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_limit(directed_rows[r].limit);
            end else begin
                send_request(directed_rows[r].op, directed_rows[r].slot,
                             directed_rows[r].typed, directed_rows[r].want);
            end
        end
        directed_sent = requests_sent;

        for (int p = 0; p < 8; p++) begin
            write_limit(LIMIT_W'(phase_limit[p]));
            // keep one phase free of idling on both sides
            send_gaps = (p != 5);
            recv_gaps = (p != 5);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 50) begin
                    // hold the receiver off and keep offering to back up the queue
                    hold_req_cnt++;
                    send_gaps = 1'b0;
                end
                if (p == 0 && n == 90) send_gaps = 1'b1;
                op   = ($urandom_range(99) < phase_alloc[p]) ? OP_ALLOC : OP_FREE;
                slot = (op == OP_FREE) ? pick_free_slot() : SLOT_W'($urandom_range(255));
                send_request(op, slot, 1'b0, '0);
            end
        end
        i_s_tvalid <= 1'b0;

        while (grant_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d directed) over 8 limit settings, %0d results checked",
                 requests_sent, directed_sent, results_seen);
        $display("Saw %0d full reports, %0d frees of unused indices, top mark %0d",
                 full_seen, not_in_use_seen, top_mark);
        if (mismatches == 0 && grant_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
